[hdl/svge_pkg.sv]
// ----------------------------------------------------------------------------
// svge_pkg
// Shared types and constants for the state vector gate engine.
// ----------------------------------------------------------------------------
package svge_pkg;

    localparam logic [2:0] FUNC_HAD   = 3'd0;
    localparam logic [2:0] FUNC_PHASE = 3'd1;
    localparam logic [2:0] FUNC_CNOT  = 3'd2;
    localparam logic [2:0] FUNC_READ  = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAME  = 2'd2;

    localparam logic signed [31:0] INV_SQRT2_Q30 = 32'sd759250125;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HAD,
        OP_PHASE,
        OP_CNOT,
        OP_READ,
        OP_CLEAR
    } op_t;

    // classified command; qubit fields already mapped to index bit positions
    typedef struct packed {
        op_t        op;
        logic [1:0] status;
        logic [4:0] bit_a;
        logic [4:0] bit_b;
        logic [19:0] index;
        logic [4:0] nq;
    } cmd_t;

endpackage

[hdl/svge_front.sv]
// ----------------------------------------------------------------------------
// svge_front
// Accepts commands, checks ranges and classifies them into queue entries.
// ----------------------------------------------------------------------------
module svge_front #(
    parameter int MAX_QUBITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  logic [2:0]           func,
    input  logic [3:0]           qubit_a,
    input  logic [3:0]           qubit_b,
    input  logic [9:0]           amp_index,
    input  logic [3:0]           num_qubits,
    output logic                 q_valid,
    input  logic                 q_ready,
    output svge_pkg::cmd_t       q_cmd
);

    localparam int QD = 2;

    svge_pkg::cmd_t fifo_reg [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    svge_pkg::cmd_t c;
    logic [4:0] n;
    logic [4:0] qa, qb;

    assign ready   = (cnt_reg != 2'(QD));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rp_reg];

    always_comb
    begin
        if (num_qubits == 4'd0)
            n = 5'd1;
        else if (32'(num_qubits) > MAX_QUBITS)
            n = 5'(MAX_QUBITS);
        else
            n = 5'(num_qubits);
        qa = 5'(qubit_a);
        qb = 5'(qubit_b);
        c.nq     = n;
        c.status = svge_pkg::STAT_OK;
        c.op     = svge_pkg::OP_NONE;
        c.bit_a  = 5'(n - 5'd1 - qa);
        c.bit_b  = 5'(n - 5'd1 - qb);
        c.index  = 20'(amp_index);
        case (func)
            svge_pkg::FUNC_HAD, svge_pkg::FUNC_PHASE:
            begin
                if (qa >= n)
                    c.status = svge_pkg::STAT_RANGE;
                else
                    c.op = (func == svge_pkg::FUNC_HAD) ? svge_pkg::OP_HAD
                                                         : svge_pkg::OP_PHASE;
            end
            svge_pkg::FUNC_CNOT:
            begin
                if (qa >= n || qb >= n)
                    c.status = svge_pkg::STAT_RANGE;
                else if (qa == qb)
                    c.status = svge_pkg::STAT_SAME;
                else
                    c.op = svge_pkg::OP_CNOT;
            end
            svge_pkg::FUNC_READ:
            begin
                if ((32'(amp_index) >> n) != 0)
                    c.status = svge_pkg::STAT_RANGE;
                else
                    c.op = svge_pkg::OP_READ;
            end
            svge_pkg::FUNC_CLEAR:
                c.op = svge_pkg::OP_CLEAR;
            default:
                c.op = svge_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
            fifo_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (valid && ready)
                wp_reg <= wp_reg + 1'b1;
            if (q_valid && q_ready)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(valid && ready) - 2'(q_valid && q_ready);
        end
    end

endmodule

[hdl/svge_back.sv]
// ----------------------------------------------------------------------------
// svge_back
// Sweeps the amplitude memory for one command, one pair at a time,
// and produces the result transaction.
// ----------------------------------------------------------------------------
module svge_back #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  svge_pkg::cmd_t              q_cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [AMP_WIDTH-1:0] amp_real,
    output logic signed [AMP_WIDTH-1:0] amp_imag,
    output logic [1:0]                  status
);

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int W2    = 2 * AMP_WIDTH;
    localparam int PW    = AMP_WIDTH + 1 + 32;
    localparam logic signed [AMP_WIDTH-1:0] AMAX = {1'b0, {(AMP_WIDTH-1){1'b1}}};
    localparam logic signed [AMP_WIDTH-1:0] AMIN = {1'b1, {(AMP_WIDTH-1){1'b0}}};
    localparam logic signed [AMP_WIDTH-1:0] AONE = AMP_WIDTH'(1) <<< (AMP_WIDTH-2);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_MUL, S_RD2, S_PRD, S_WR0, S_WR1, S_CLR, S_OUT
    } state_t;

    logic [W2-1:0] mem [DEPTH];
    logic [W2-1:0] rdata_reg;

    state_t state_reg;
    svge_pkg::cmd_t cmd_reg;
    logic [AW:0] cnt_reg;
    logic [AW-1:0] i0_reg, i1_reg;
    logic [W2-1:0] a0_reg, a1_reg;
    logic signed [PW-1:0] p_reg [4];
    logic signed [AMP_WIDTH-1:0] r_re_reg, r_im_reg;
    logic [1:0] r_st_reg;
    logic signed [AMP_WIDTH-1:0] o_re_reg, o_im_reg;
    logic [1:0] o_st_reg;
    logic out_valid_reg;

    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [W2-1:0] mem_wd;
    logic [AW-1:0] i0, tbit, abit;
    logic [AW:0] total, limit;
    logic signed [AMP_WIDTH:0] s [4];
    logic signed [AMP_WIDTH-1:0] h [4];

    function automatic logic signed [AMP_WIDTH-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        begin
            t = (p + PW'(64'sd536870912)) >>> 30;
            if (t > PW'(AMAX))
                rnd = AMAX;
            else if (t < PW'(AMIN))
                rnd = AMIN;
            else
                rnd = AMP_WIDTH'(t);
        end
    endfunction

    function automatic logic [AW-1:0] ins0(input logic [AW:0] k, input logic [4:0] b);
        logic [AW-1:0] lo;
        begin
            lo   = AW'(k) & AW'((1 << b) - 1);
            ins0 = AW'((k >> b) << (b + 1)) | lo;
        end
    endfunction

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign amp_real  = o_re_reg;
    assign amp_imag  = o_im_reg;
    assign status    = o_st_reg;

    assign abit  = AW'(1) << cmd_reg.bit_a;
    assign tbit  = (cmd_reg.op == svge_pkg::OP_CNOT) ? AW'(1) << cmd_reg.bit_b : abit;
    assign total = (AW+1)'(1) << cmd_reg.nq;
    // H and phase walk pairs, CNOT walks every index
    assign limit = (cmd_reg.op == svge_pkg::OP_CNOT) ? total : (total >> 1);

    always_comb
    begin
        if (cmd_reg.op == svge_pkg::OP_CNOT)
            i0 = AW'(cnt_reg);
        else
            i0 = ins0(cnt_reg, cmd_reg.bit_a);
        s[0] = (AMP_WIDTH+1)'(signed'(a0_reg[W2-1:AMP_WIDTH]))
             + (AMP_WIDTH+1)'(signed'(a1_reg[W2-1:AMP_WIDTH]));
        s[1] = (AMP_WIDTH+1)'(signed'(a0_reg[AMP_WIDTH-1:0]))
             + (AMP_WIDTH+1)'(signed'(a1_reg[AMP_WIDTH-1:0]));
        s[2] = (AMP_WIDTH+1)'(signed'(a0_reg[W2-1:AMP_WIDTH]))
             - (AMP_WIDTH+1)'(signed'(a1_reg[W2-1:AMP_WIDTH]));
        s[3] = (AMP_WIDTH+1)'(signed'(a0_reg[AMP_WIDTH-1:0]))
             - (AMP_WIDTH+1)'(signed'(a1_reg[AMP_WIDTH-1:0]));
        for (int k = 0; k < 4; k++)
            h[k] = rnd(p_reg[k]);
        mem_we = 1'b0;
        mem_wa = i0_reg;
        mem_wd = a0_reg;
        mem_ra = i0_reg;
        case (state_reg)
            S_IDLE:
                mem_ra = AW'(q_cmd.index);
            S_RD1:
                mem_ra = i0_reg;
            S_MUL:
                mem_ra = i1_reg;
            S_WR0:
            begin
                mem_we = 1'b1;
                mem_wa = i0_reg;
                case (cmd_reg.op)
                    svge_pkg::OP_HAD:   mem_wd = {h[0], h[1]};
                    svge_pkg::OP_PHASE: mem_wd = a0_reg;
                    default:            mem_wd = a1_reg;
                endcase
            end
            S_WR1:
            begin
                mem_we = 1'b1;
                mem_wa = i1_reg;
                case (cmd_reg.op)
                    svge_pkg::OP_HAD:
                        mem_wd = {h[2], h[3]};
                    svge_pkg::OP_PHASE:
                        mem_wd = {(a1_reg[AMP_WIDTH-1:0] == AMIN) ? AMAX
                                  : AMP_WIDTH'(-signed'(a1_reg[AMP_WIDTH-1:0])),
                                  a1_reg[W2-1:AMP_WIDTH]};
                    default:
                        mem_wd = a0_reg;
                endcase
            end
            S_CLR:
            begin
                mem_we = 1'b1;
                mem_wa = AW'(cnt_reg);
                mem_wd = (cnt_reg == '0) ? {AONE, AMP_WIDTH'(0)} : '0;
            end
            default:
                mem_ra = i0_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            r_st_reg      <= '0;
            r_re_reg      <= '0;
            r_im_reg      <= '0;
            o_st_reg      <= '0;
            o_re_reg      <= '0;
            o_im_reg      <= '0;
            i0_reg        <= '0;
            i1_reg        <= '0;
            a0_reg        <= '0;
            a1_reg        <= '0;
            for (int k = 0; k < 4; k++)
                p_reg[k] <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg  <= q_cmd;
                        cnt_reg  <= '0;
                        r_st_reg <= q_cmd.status;
                        r_re_reg <= '0;
                        r_im_reg <= '0;
                        case (q_cmd.op)
                            svge_pkg::OP_HAD, svge_pkg::OP_PHASE, svge_pkg::OP_CNOT:
                                state_reg <= S_RD0;
                            svge_pkg::OP_READ:
                                state_reg <= S_MUL;
                            svge_pkg::OP_CLEAR:
                                state_reg <= S_CLR;
                            default:
                                state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD0:
                begin
                    if (cnt_reg >= limit)
                        state_reg <= S_OUT;
                    else if (cmd_reg.op == svge_pkg::OP_CNOT
                             && (((i0 & abit) == '0) || ((i0 & tbit) != '0)))
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                    begin
                        i0_reg    <= i0;
                        i1_reg    <= i0 | tbit;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                    state_reg <= S_MUL;
                S_MUL:
                begin
                    if (cmd_reg.op == svge_pkg::OP_READ)
                    begin
                        r_re_reg  <= rdata_reg[W2-1:AMP_WIDTH];
                        r_im_reg  <= rdata_reg[AMP_WIDTH-1:0];
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        a0_reg    <= rdata_reg;
                        state_reg <= S_RD2;
                    end
                end
                S_RD2:
                begin
                    a1_reg    <= rdata_reg;
                    state_reg <= S_PRD;
                end
                S_PRD:
                begin
                    for (int k = 0; k < 4; k++)
                        p_reg[k] <= PW'(s[k]) * PW'(svge_pkg::INV_SQRT2_Q30);
                    state_reg <= S_WR0;
                end
                S_WR0:
                    state_reg <= S_WR1;
                S_WR1:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_RD0;
                end
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (AW+1)'(DEPTH - 1))
                        state_reg <= (cmd_reg.op == svge_pkg::OP_CLEAR) ? S_OUT : S_IDLE;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        o_re_reg      <= r_re_reg;
                        o_im_reg      <= r_im_reg;
                        o_st_reg      <= r_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/state_vector_gate_engine.sv]
// ----------------------------------------------------------------------------
// state_vector_gate_engine
// Fixed-point state vector simulator applying H, phase and CNOT gates.
// ----------------------------------------------------------------------------
// Input channel valid/ready carries one command per transaction; output
// channel valid/ready returns one result transaction per command. The user
// sets num_qubits via cfg_we/cfg_data only while idle; this is not enforced.
// A gate sweeps all 2^n amplitudes held in one single-port-write memory.
// H and phase visit each amplitude pair (2^(n-1) pairs); CNOT visits every
// index and swaps the pairs whose control bit is set. Each pair passes
// through the read, product and write states in turn. Read and rejected commands skip the sweep.
// A reset-to-ground command, and also rst_n, run a clearing pass over all
// 2^MAX_QUBITS entries of the memory; the sweep takes no command
// meanwhile, while the queue still takes up to two.
// A two-entry queue sits between the command front end and the memory
// sweep. When the receiver stalls, the result is held in the output register;
// the next command may sweep meanwhile and then waits to hand over its result.
// ----------------------------------------------------------------------------
module state_vector_gate_engine #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_WIDTH  = 18
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic [3:0]                  qubit_a,
    input  logic [3:0]                  qubit_b,
    input  logic [9:0]                  amp_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [AMP_WIDTH-1:0] amp_real,
    output logic signed [AMP_WIDTH-1:0] amp_imag,
    output logic [1:0]                  status,
    input  logic                        cfg_we,
    input  logic [3:0]                  cfg_data
);

    logic [3:0] num_qubits_reg;
    logic q_valid, q_ready;
    svge_pkg::cmd_t q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_qubits_reg <= 4'd10;
        else if (cfg_we)
            num_qubits_reg <= cfg_data;
    end

    svge_front #(.MAX_QUBITS(MAX_QUBITS)) u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .func(func), .qubit_a(qubit_a), .qubit_b(qubit_b), .amp_index(amp_index),
        .num_qubits(num_qubits_reg), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd)
    );

    svge_back #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready),
        .amp_real(amp_real), .amp_imag(amp_imag), .status(status)
    );

endmodule

[verif/state_vector_gate_engine_tb.sv]
// ----------------------------------------------------------------------------
// state_vector_gate_engine_tb
// Self-checking testbench for the fixed-point state vector gate engine.
// Commands go in over a valid/ready channel with random gaps. A local model
// of the amplitude store predicts every result, and each result transaction
// is checked field by field against the oldest prediction. The qubit count
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module state_vector_gate_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NQ_MAX      = 10;
    localparam int          DEPTH       = 1 << NQ_MAX;
    localparam int          AMP_W       = 18;
    localparam longint      AMP_HI      = (64'sd1 << (AMP_W - 1)) - 1;
    localparam longint      AMP_LO      = -AMP_HI - 1;
    localparam longint      ROUND_HALF  = 64'sd1 << 29;
    localparam int          SETTLE      = 1200;
    localparam longint      CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [AMP_W-1:0] re;
        logic [AMP_W-1:0] im;
        logic [1:0]       st;
    } amp_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       func;
    logic [3:0]       qubit_a;
    logic [3:0]       qubit_b;
    logic [9:0]       amp_index;
    logic             out_valid;
    logic             out_ready;
    logic signed [AMP_W-1:0] amp_real;
    logic signed [AMP_W-1:0] amp_imag;
    logic [1:0]       status;
    logic             cfg_we;
    logic [3:0]       cfg_data;

    int               vec_re [DEPTH];
    int               vec_im [DEPTH];
    logic [3:0]       qubit_reg;
    amp_result_t      pending_results [$];
    int               mismatches;
    longint           cycles;
    bit               gaps_on;

    state_vector_gate_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .qubit_a   (qubit_a),
        .qubit_b   (qubit_b),
        .amp_index (amp_index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .amp_real  (amp_real),
        .amp_imag  (amp_imag),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- model of the amplitude store ----------------

    function automatic int clip_amp(longint v);
        if (v > AMP_HI)
            return int'(AMP_HI);
        if (v < AMP_LO)
            return int'(AMP_LO);
        return int'(v);
    endfunction

    function automatic int scale_inv_root2(longint s);
        longint p;
        p = s * longint'(svge_pkg::INV_SQRT2_Q30) + ROUND_HALF;
        return clip_amp(p >>> 30);
    endfunction

    function automatic int qubits_active();
        if (qubit_reg == 0)
            return 1;
        if (qubit_reg > NQ_MAX)
            return NQ_MAX;
        return qubit_reg;
    endfunction

    task automatic clear_vector();
        for (int i = 0; i < DEPTH; i++)
        begin
            vec_re[i] = 0;
            vec_im[i] = 0;
        end
        vec_re[0] = 1 << (AMP_W - 2);
    endtask

    task automatic predict_command(input logic [2:0] f, input logic [3:0] qa,
                                   input logic [3:0] qb, input logic [9:0] idx,
                                   output amp_result_t r);
        int  n;
        int  total;
        int  ba;
        int  bb;
        int  t0;
        int  t1;
        longint r0;
        longint r1;
        longint m0;
        longint m1;
        n = qubits_active();
        total = 1 << n;
        r.re = '0;
        r.im = '0;
        r.st = svge_pkg::STAT_OK;
        if (f == svge_pkg::FUNC_HAD || f == svge_pkg::FUNC_PHASE)
        begin
            if (qa >= n)
                r.st = svge_pkg::STAT_RANGE;
            else
            begin
                ba = 1 << (n - 1 - qa);
                for (int i = 0; i < total; i++)
                begin
                    if ((i & ba) != 0)
                        continue;
                    if (f == svge_pkg::FUNC_HAD)
                    begin
                        r0 = vec_re[i];
                        r1 = vec_re[i | ba];
                        m0 = vec_im[i];
                        m1 = vec_im[i | ba];
                        vec_re[i] = scale_inv_root2(r0 + r1);
                        vec_im[i] = scale_inv_root2(m0 + m1);
                        vec_re[i | ba] = scale_inv_root2(r0 - r1);
                        vec_im[i | ba] = scale_inv_root2(m0 - m1);
                    end
                    else
                    begin
                        t0 = vec_re[i | ba];
                        t1 = vec_im[i | ba];
                        vec_re[i | ba] = clip_amp(-longint'(t1));
                        vec_im[i | ba] = t0;
                    end
                end
            end
        end
        else if (f == svge_pkg::FUNC_CNOT)
        begin
            if (qa >= n || qb >= n)
                r.st = svge_pkg::STAT_RANGE;
            else if (qa == qb)
                r.st = svge_pkg::STAT_SAME;
            else
            begin
                ba = 1 << (n - 1 - qa);
                bb = 1 << (n - 1 - qb);
                for (int i = 0; i < total; i++)
                begin
                    if ((i & ba) != 0 && (i & bb) == 0)
                    begin
                        t0 = vec_re[i];
                        t1 = vec_im[i];
                        vec_re[i] = vec_re[i | bb];
                        vec_im[i] = vec_im[i | bb];
                        vec_re[i | bb] = t0;
                        vec_im[i | bb] = t1;
                    end
                end
            end
        end
        else if (f == svge_pkg::FUNC_READ)
        begin
            if (idx >= total)
                r.st = svge_pkg::STAT_RANGE;
            else
            begin
                r.re = vec_re[idx][AMP_W-1:0];
                r.im = vec_im[idx][AMP_W-1:0];
            end
        end
        else if (f == svge_pkg::FUNC_CLEAR)
            clear_vector();
    endtask

    // ---------------- command side ----------------

    task automatic send_command(input logic [2:0] f, input logic [3:0] qa,
                                input logic [3:0] qb, input logic [9:0] idx);
        int          gap;
        amp_result_t r;
        gap = gaps_on ? int'($urandom_range(0, 11)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        qubit_a   <= qa;
        qubit_b   <= qb;
        amp_index <= idx;
        predict_command(f, qa, qb, idx, r);
        pending_results.push_back(r);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_qubits(input logic [3:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        qubit_reg = v;
        @(posedge clk);
    endtask

    // ---------------- result side ----------------

    initial
    begin
        int          stall;
        amp_result_t e;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: re=%0d im=%0d st=%0d",
                                 amp_real, amp_imag, status);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (amp_real !== e.re || amp_imag !== e.im || status !== e.st)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                     $signed(e.re), $signed(e.im), e.st,
                                     amp_real, amp_imag, status);
                    end
                end
                stall = gaps_on ? int'($urandom_range(0, 11)) : 0;
            end
            else if (stall > 0)
                stall--;
            out_ready <= (stall == 0);
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_full_width();
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_HAD, 4'd0, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_PHASE, 4'd9, 4'd15, 10'd1023);
        send_command(svge_pkg::FUNC_CNOT, 4'd0, 4'd9, 10'd0);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd512);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd1023);
        send_command(svge_pkg::FUNC_CNOT, 4'd3, 4'd3, 10'd0);
        send_command(svge_pkg::FUNC_CNOT, 4'd1, 4'd12, 10'd0);
        send_command(svge_pkg::FUNC_HAD, 4'd15, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_PHASE, 4'd10, 4'd0, 10'd0);
        send_command(3'd5, 4'd0, 4'd0, 10'd0);
        send_command(3'd6, 4'd15, 4'd15, 10'd1023);
        send_command(3'd7, 4'd0, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_CLEAR, 4'd0, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd0);
    endtask

    task automatic test_directed_qubit_limits();
        write_qubits(4'd0);
        send_command(svge_pkg::FUNC_HAD, 4'd0, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd1);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd2);
        send_command(svge_pkg::FUNC_PHASE, 4'd1, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_PHASE, 4'd0, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd1);
        write_qubits(4'd15);
        send_command(svge_pkg::FUNC_HAD, 4'd9, 4'd0, 10'd0);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd1);
        send_command(svge_pkg::FUNC_READ, 4'd0, 4'd0, 10'd1023);
    endtask

    task automatic test_random_gates(input logic [3:0] nq_setting, input int count);
        int         n;
        int         sel;
        logic [2:0] f;
        logic [3:0] qa;
        logic [3:0] qb;
        logic [9:0] idx;
        write_qubits(nq_setting);
        n = qubits_active();
        for (int k = 0; k < count; k++)
        begin
            if (k % 24 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (k == count / 2)
                wait_idle();
            if ($urandom_range(0, 99) < 15)
            begin
                f   = 3'($urandom);
                qa  = 4'($urandom);
                qb  = 4'($urandom);
                idx = 10'($urandom);
                if (f == svge_pkg::FUNC_CLEAR && $urandom_range(0, 3) != 0)
                    f = svge_pkg::FUNC_READ;
            end
            else
            begin
                sel = int'($urandom_range(0, 99));
                if (sel < 18)
                    f = svge_pkg::FUNC_HAD;
                else if (sel < 30)
                    f = svge_pkg::FUNC_PHASE;
                else if (sel < 45)
                    f = svge_pkg::FUNC_CNOT;
                else if (sel < 96)
                    f = svge_pkg::FUNC_READ;
                else
                    f = svge_pkg::FUNC_CLEAR;
                qa  = 4'($urandom_range(0, n - 1));
                qb  = 4'($urandom_range(0, n - 1));
                if (qa == qb && n > 1 && $urandom_range(0, 7) != 0)
                    qb = 4'((qa + 1) % n);
                idx = 10'($urandom_range(0, (1 << n) - 1));
            end
            send_command(f, qa, qb, idx);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = '0;
        qubit_a   = '0;
        qubit_b   = '0;
        amp_index = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        cycles    = 0;
        mismatches = 0;
        gaps_on   = 1'b1;
        qubit_reg = 4'd10;
        clear_vector();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        test_directed_full_width();
        test_directed_qubit_limits();
        test_random_gates(4'd1, 72);
        test_random_gates(4'd3, 72);
        test_random_gates(4'd5, 72);
        test_random_gates(4'd7, 72);
        test_random_gates(4'd10, 72);
        test_random_gates(4'd2, 72);
        test_random_gates(4'd6, 72);
        test_random_gates(4'd15, 72);

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hdl/svge_pkg.sv
hdl/svge_front.sv
hdl/svge_back.sv
hdl/state_vector_gate_engine.sv
verif/state_vector_gate_engine_tb.sv
